[rtl/nat_pkg.sv]
// Shared types and constants for the no-alias transitive closure block.
// Used by nat_ctrl, nat_dp and no_alias_transitive_closure.
package nat_pkg;

  localparam int unsigned MAX_VALUES = 16;
  localparam int unsigned IDX_W      = $clog2(MAX_VALUES);
  localparam int unsigned CNT_W      = $clog2(MAX_VALUES + 1);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned USED_W     = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } nat_op_e;

  typedef struct packed {
    logic             load_in;
    logic             look;
    logic             apply;
    logic             close;
    logic [IDX_W-1:0] pivot;
    logic             load_out;
  } nat_cmd_t;

  typedef struct packed {
    logic             is_query;
    logic             full;
    logic [CNT_W-1:0] count;
  } nat_sts_t;

endpackage

[rtl/nat_ctrl.sv]
// Sequencer for the no-alias closure block: lookup, apply, pivot walk, result.
// Depends on nat_pkg; drives nat_dp through nat_cmd_t.
module nat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  nat_pkg::nat_sts_t sts_i,
  output nat_pkg::nat_cmd_t cmd_o
);
  import nat_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY,
    ST_CLOSE,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] k_q;
  logic             out_valid_q;
  logic             slot_free;
  logic             last_pivot;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign last_pivot = (CNT_W'(k_q) + CNT_W'(1)) == sts_i.count;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.look     = (state_q == ST_LOOK);
    cmd_o.apply    = (state_q == ST_APPLY);
    cmd_o.close    = (state_q == ST_CLOSE);
    cmd_o.pivot    = k_q;
    cmd_o.load_out = (state_q == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state_q <= sts_i.is_query ? ST_DONE : ST_APPLY;
        end
        ST_APPLY: begin
          k_q     <= '0;
          state_q <= sts_i.full ? ST_DONE : ST_CLOSE;
        end
        ST_CLOSE: begin
          if (last_pivot) begin
            state_q <= ST_DONE;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_pivot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLOSE |-> CNT_W'(k_q) < sts_i.count)
    else $error("pivot beyond used entries");

  a_accept_to_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_LOOK)
    else $error("accepted word did not start lookup");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && slot_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not presented after done");

endmodule

[rtl/nat_dp.sv]
// Datapath: key table with parallel compare, relation matrix, entry count,
// row-parallel closure update and result register. Depends on nat_pkg.
module nat_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nat_pkg::nat_cmd_t          cmd_i,
  output nat_pkg::nat_sts_t          sts_o,
  input  logic                       command_i,
  input  logic [nat_pkg::KEY_W-1:0]  key_a_i,
  input  logic [nat_pkg::KEY_W-1:0]  key_b_i,
  output logic                       can_alias_o,
  output logic                       table_full_o,
  output logic [nat_pkg::USED_W-1:0] used_entries_o
);
  import nat_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  nat_op_e             cmd_q;
  logic [KEY_W-1:0]    key_a_q, key_b_q;
  logic [KEY_W-1:0]    key_q [MAX_VALUES];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [MAX_VALUES-1:0] mat_q [MAX_VALUES];
  logic [MAX_VALUES-1:0] mat_d [MAX_VALUES];
  logic                hit_a_q, hit_b_q;
  logic [IDX_W-1:0]    idx_a_q, idx_b_q;
  logic                full_q;
  logic                can_alias_q, table_full_q;
  logic [USED_W-1:0]   used_q;

  logic [MAX_VALUES-1:0] match_a, match_b;
  logic [IDX_W-1:0]    idx_a_w, idx_b_w;
  logic                need_a, need_b, same_w, full_w, do_apply;
  logic [SUM_W-1:0]    sum_w;
  logic [IDX_W-1:0]    slot_a, slot_b, new_a, new_b, row_sel;
  logic [MAX_VALUES-1:0] prow;

  // parallel key compare against used entries
  always_comb begin
    idx_a_w = '0;
    idx_b_w = '0;
    for (int i = 0; i < MAX_VALUES; i++) begin
      match_a[i] = (CNT_W'(i) < count_q) && (key_q[i] == key_a_q);
      match_b[i] = (CNT_W'(i) < count_q) && (key_q[i] == key_b_q);
      if (match_a[i]) idx_a_w = idx_a_w | IDX_W'(i);
      if (match_b[i]) idx_b_w = idx_b_w | IDX_W'(i);
    end
  end

  assign same_w   = (key_a_q == key_b_q);
  assign need_a   = !hit_a_q;
  assign need_b   = !hit_b_q && !same_w;
  assign sum_w    = SUM_W'(count_q) + SUM_W'(need_a) + SUM_W'(need_b);
  assign full_w   = sum_w > SUM_W'(MAX_VALUES);
  assign do_apply = cmd_i.apply && !full_w;
  assign slot_a   = count_q[IDX_W-1:0];
  assign slot_b   = IDX_W'(count_q + CNT_W'(need_a));
  assign new_a    = hit_a_q ? idx_a_q : slot_a;
  assign new_b    = hit_b_q ? idx_b_q : (same_w ? new_a : slot_b);
  assign row_sel  = cmd_i.close ? cmd_i.pivot : idx_a_q;
  assign prow     = mat_q[row_sel];

  always_comb begin
    count_d = count_q;
    mat_d   = mat_q;
    if (do_apply) begin
      count_d             = CNT_W'(sum_w);
      mat_d[new_a][new_b] = 1'b1;
      mat_d[new_b][new_a] = 1'b1;
    end
    if (cmd_i.close) begin
      for (int i = 0; i < MAX_VALUES; i++) begin
        if (mat_q[i][cmd_i.pivot]) mat_d[i] = mat_q[i] | prow;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < MAX_VALUES; i++) mat_q[i] <= '0;
    end else begin
      count_q <= count_d;
      mat_q   <= mat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= nat_op_e'(command_i);
      key_a_q <= key_a_i;
      key_b_q <= key_b_i;
    end
    if (cmd_i.look) begin
      hit_a_q <= |match_a;
      hit_b_q <= |match_b;
      idx_a_q <= idx_a_w;
      idx_b_q <= idx_b_w;
    end
    if (cmd_i.apply) begin
      full_q <= full_w;
    end
    if (do_apply) begin
      for (int i = 0; i < MAX_VALUES; i++) begin
        if (need_a && IDX_W'(i) == slot_a) key_q[i] <= key_a_q;
        if (need_b && IDX_W'(i) == slot_b) key_q[i] <= key_b_q;
      end
    end
    if (cmd_i.load_out) begin
      if (cmd_q == CMD_QUERY) begin
        can_alias_q  <= !(hit_a_q && hit_b_q) || !prow[idx_b_q];
        table_full_q <= 1'b0;
      end else begin
        can_alias_q  <= 1'b0;
        table_full_q <= full_q;
      end
      used_q <= USED_W'(count_q);
    end
  end

  assign sts_o.is_query = (cmd_q == CMD_QUERY);
  assign sts_o.full     = full_w;
  assign sts_o.count    = count_q;

  assign can_alias_o    = can_alias_q;
  assign table_full_o   = table_full_q;
  assign used_entries_o = used_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VALUES))
    else $error("entry count above table size");

  a_full_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && full_w |=> $stable(count_q))
    else $error("rejected insert changed entry count");

  a_unused_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < CNT_W'(MAX_VALUES) |-> mat_q[MAX_VALUES-1] == '0)
    else $error("relation set on unused entry");

endmodule

[rtl/no_alias_transitive_closure.sv]
// Top level of the no-alias transitive closure block: nat_ctrl plus nat_dp.
// Depends on nat_pkg, nat_ctrl and nat_dp.
//
//   channel | handshake              | word
//   in      | in_valid_i / in_stall_o | command_i, key_a_i, key_b_i
//   out     | out_valid_o / out_stall_i | can_alias_o, table_full_o, used_entries_o
//
// One word at a time: a query runs lookup then result; an insert runs lookup,
// apply, then a walk over the N entries in use after it (one Warshall pivot per
// cycle, all rows in parallel); a rejected insert skips the walk. The next word
// is taken the cycle after the result is loaded, even while out_stall_i holds it.
// Reset clears the entry count and the relation matrix; no sweep is needed.
module no_alias_transitive_closure (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [nat_pkg::KEY_W-1:0]  key_a_i,
  input  logic [nat_pkg::KEY_W-1:0]  key_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       can_alias_o,
  output logic                       table_full_o,
  output logic [nat_pkg::USED_W-1:0] used_entries_o
);
  import nat_pkg::*;

  nat_cmd_t cmd;
  nat_sts_t sts;

  nat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  nat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .command_i      (command_i),
    .key_a_i        (key_a_i),
    .key_b_i        (key_b_i),
    .can_alias_o    (can_alias_o),
    .table_full_o   (table_full_o),
    .used_entries_o (used_entries_o)
  );

endmodule
